@@ hw/rtl/h2a_pkg.sv @@
package h2a_pkg;

	localparam int HUE_W = 15;
	localparam int BYTE_W = 8;
	localparam int HUE_FRACTION_BITS_DEF = 6;

	// sector width is 60 << frac = 15 << (frac + 2); the 255 * 15 part is divided by reciprocal
	localparam int SPAN_BASE = 60;
	localparam int SPAN_SHIFT_EXTRA = 2;
	localparam int DIV_BASE = 3825;
	localparam int SECTOR_COUNT = 6;

	// floor(x / 3825) == (x * DIV_MULT) >> DIV_SHIFT for every x below 2^DIV_IN_W
	localparam int DIV_IN_W = 20;
	localparam int DIV_MULT_W = 21;
	localparam logic [DIV_MULT_W-1:0] DIV_MULT = 21'd1122868;
	localparam int DIV_SHIFT = 32;

	typedef enum logic [2:0] {
		SEC_RED     = 3'd0,
		SEC_YELLOW  = 3'd1,
		SEC_GREEN   = 3'd2,
		SEC_CYAN    = 3'd3,
		SEC_BLUE    = 3'd4,
		SEC_MAGENTA = 3'd5
	} sector_t;

	// load enables for the lane stages
	typedef struct packed {
		logic ld2;
		logic ld3;
		logic ld4;
	} h2a_adv_t;

endpackage

@@ hw/rtl/h2a_sector.sv @@
module h2a_sector #(
	parameter int HUE_FRACTION_BITS = h2a_pkg::HUE_FRACTION_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic [h2a_pkg::HUE_W-1:0]              hue,
	output h2a_pkg::sector_t                       sector_s1,
	output logic [$clog2(h2a_pkg::SPAN_BASE << HUE_FRACTION_BITS)-1:0] rem_s1,
	output logic                                   oor_s1
);

	localparam int SPAN = h2a_pkg::SPAN_BASE << HUE_FRACTION_BITS;
	localparam int REM_W = $clog2(SPAN);
	localparam int SEC_W = $clog2(h2a_pkg::SECTOR_COUNT * SPAN + 1);
	// hue can run past the last sector boundary, so compare at the wider of the two
	localparam int CMP_W = (SEC_W > h2a_pkg::HUE_W) ? SEC_W : h2a_pkg::HUE_W;

	localparam logic [CMP_W-1:0] B1 = CMP_W'(SPAN);
	localparam logic [CMP_W-1:0] B2 = CMP_W'(2 * SPAN);
	localparam logic [CMP_W-1:0] B3 = CMP_W'(3 * SPAN);
	localparam logic [CMP_W-1:0] B4 = CMP_W'(4 * SPAN);
	localparam logic [CMP_W-1:0] B5 = CMP_W'(5 * SPAN);
	localparam logic [CMP_W-1:0] B6 = CMP_W'(6 * SPAN);

	logic [CMP_W-1:0] hue_x;
	logic [CMP_W-1:0] base;
	logic [CMP_W-1:0] diff;
	h2a_pkg::sector_t sec;
	logic             oor;

	assign hue_x = CMP_W'(hue);

	always_comb begin
		sec = h2a_pkg::SEC_RED;
		base = '0;
		oor = 1'b0;
		priority if (hue_x >= B6) begin
			oor = 1'b1;
		end else if (hue_x >= B5) begin
			sec = h2a_pkg::SEC_MAGENTA;
			base = B5;
		end else if (hue_x >= B4) begin
			sec = h2a_pkg::SEC_BLUE;
			base = B4;
		end else if (hue_x >= B3) begin
			sec = h2a_pkg::SEC_CYAN;
			base = B3;
		end else if (hue_x >= B2) begin
			sec = h2a_pkg::SEC_GREEN;
			base = B2;
		end else if (hue_x >= B1) begin
			sec = h2a_pkg::SEC_YELLOW;
			base = B1;
		end else begin
			sec = h2a_pkg::SEC_RED;
		end
	end

	assign diff = hue_x - base;

	always_ff @(posedge clk) begin
		if (en) begin
			sector_s1 <= sec;
			rem_s1 <= diff[REM_W-1:0];
			oor_s1 <= oor;
		end
	end

endmodule

@@ hw/rtl/h2a_lane.sv @@
module h2a_lane #(
	parameter int HUE_FRACTION_BITS = h2a_pkg::HUE_FRACTION_BITS_DEF
) (
	input  logic                                   clk,
	input  h2a_pkg::h2a_adv_t                      adv,
	input  logic [$clog2((h2a_pkg::SPAN_BASE << HUE_FRACTION_BITS) + 1)-1:0] coef,
	input  logic [h2a_pkg::BYTE_W-1:0]             sat,
	input  logic [h2a_pkg::BYTE_W-1:0]             val,
	output logic [h2a_pkg::BYTE_W-1:0]             res_s4
);

	localparam int SPAN = h2a_pkg::SPAN_BASE << HUE_FRACTION_BITS;
	localparam int C_W = $clog2(SPAN + 1);
	localparam int FULL = 255 * SPAN;
	localparam int HALF = FULL / 2;
	localparam int FULL_W = $clog2(FULL + 1);
	localparam int N_W = FULL_W + h2a_pkg::BYTE_W;
	localparam int SH = HUE_FRACTION_BITS + h2a_pkg::SPAN_SHIFT_EXTRA;
	localparam int XW = h2a_pkg::DIV_IN_W;
	localparam int M_W = XW + h2a_pkg::DIV_MULT_W;

	logic [C_W+h2a_pkg::BYTE_W-1:0] prod;
	logic [FULL_W-1:0]              w_s2;
	logic [N_W-1:0]                 n;
	logic [N_W:0]                   nr;
	logic [N_W:0]                   nsh;
	logic [XW-1:0]                  x_s3;
	logic [M_W-1:0]                 m;

	// weight = 255*S - c*s, never negative since c <= S
	assign prod = coef * sat;

	always_ff @(posedge clk) begin
		if (adv.ld2) begin
			w_s2 <= FULL_W'(FULL) - prod[FULL_W-1:0];
		end
	end

	// add half the divisor, then drop the power-of-two part of it
	assign n = val * w_s2;
	assign nr = {1'b0, n} + (N_W + 1)'(HALF);
	assign nsh = nr >> SH;

	always_ff @(posedge clk) begin
		if (adv.ld3) begin
			x_s3 <= nsh[XW-1:0];
		end
	end

	assign m = x_s3 * h2a_pkg::DIV_MULT;

	always_ff @(posedge clk) begin
		if (adv.ld4) begin
			res_s4 <= m[h2a_pkg::DIV_SHIFT +: h2a_pkg::BYTE_W];
		end
	end

endmodule

@@ hw/rtl/hsv_to_argb_converter.sv @@
// path: an accepted input beat is registered in stages 1 to 4, then in the output register
// throughput: one beat per cycle while out_stall is low; stage 4 holds the reciprocal multiply
// each stage advances when it is empty or the stage after it moves, so bubbles collapse
// reset clears the stage valid bits only; the pipeline comes up empty
module hsv_to_argb_converter #(
	parameter int HUE_FRACTION_BITS = h2a_pkg::HUE_FRACTION_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [h2a_pkg::HUE_W-1:0]  hue,
	input  logic [h2a_pkg::BYTE_W-1:0] saturation,
	input  logic [h2a_pkg::BYTE_W-1:0] brightness,
	input  logic [h2a_pkg::BYTE_W-1:0] alpha_in,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [h2a_pkg::BYTE_W-1:0] alpha_out,
	output logic [h2a_pkg::BYTE_W-1:0] red,
	output logic [h2a_pkg::BYTE_W-1:0] green,
	output logic [h2a_pkg::BYTE_W-1:0] blue,
	output logic                       hue_out_of_range
);

	localparam int SPAN = h2a_pkg::SPAN_BASE << HUE_FRACTION_BITS;
	localparam int REM_W = $clog2(SPAN);
	localparam int C_W = $clog2(SPAN + 1);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	h2a_pkg::h2a_adv_t adv;

	h2a_pkg::sector_t sector_s1, sector_s2, sector_s3, sector_s4;
	logic             oor_s1, oor_s2, oor_s3, oor_s4;
	logic [REM_W-1:0] rem_s1;
	logic [h2a_pkg::BYTE_W-1:0] sat_s1, val_s1, val_s2, val_s3, val_s4;
	logic [h2a_pkg::BYTE_W-1:0] a_s1, a_s2, a_s3, a_s4;
	logic [h2a_pkg::BYTE_W-1:0] p_s4, q_s4, t_s4;
	logic [C_W-1:0] coef_p, coef_q, coef_t;
	logic [h2a_pkg::BYTE_W-1:0] r_d, g_d, b_d;

	assign rdy5 = !out_valid || !out_stall;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_stall = !rdy1;

	assign adv.ld2 = rdy2;
	assign adv.ld3 = rdy3;
	assign adv.ld4 = rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) out_valid <= v_s4;
		end
	end

	h2a_sector #(
		.HUE_FRACTION_BITS(HUE_FRACTION_BITS)
	) u_sector (
		.clk(clk),
		.en(rdy1),
		.hue(hue),
		.sector_s1(sector_s1),
		.rem_s1(rem_s1),
		.oor_s1(oor_s1)
	);

	always_ff @(posedge clk) begin
		if (rdy1) begin
			sat_s1 <= saturation;
			val_s1 <= brightness;
			a_s1 <= alpha_in;
		end
		if (rdy2) begin
			sector_s2 <= sector_s1;
			oor_s2 <= oor_s1;
			val_s2 <= val_s1;
			a_s2 <= a_s1;
		end
		if (rdy3) begin
			sector_s3 <= sector_s2;
			oor_s3 <= oor_s2;
			val_s3 <= val_s2;
			a_s3 <= a_s2;
		end
		if (rdy4) begin
			sector_s4 <= sector_s3;
			oor_s4 <= oor_s3;
			val_s4 <= val_s3;
			a_s4 <= a_s3;
		end
	end

	// p uses the full sector width, q the remainder, t what is left of the sector
	assign coef_p = C_W'(SPAN);
	assign coef_q = C_W'(rem_s1);
	assign coef_t = C_W'(SPAN) - C_W'(rem_s1);

	h2a_lane #(
		.HUE_FRACTION_BITS(HUE_FRACTION_BITS)
	) u_lane_p (
		.clk(clk),
		.adv(adv),
		.coef(coef_p),
		.sat(sat_s1),
		.val(val_s2),
		.res_s4(p_s4)
	);

	h2a_lane #(
		.HUE_FRACTION_BITS(HUE_FRACTION_BITS)
	) u_lane_q (
		.clk(clk),
		.adv(adv),
		.coef(coef_q),
		.sat(sat_s1),
		.val(val_s2),
		.res_s4(q_s4)
	);

	h2a_lane #(
		.HUE_FRACTION_BITS(HUE_FRACTION_BITS)
	) u_lane_t (
		.clk(clk),
		.adv(adv),
		.coef(coef_t),
		.sat(sat_s1),
		.val(val_s2),
		.res_s4(t_s4)
	);

	always_comb begin
		unique case (sector_s4)
			h2a_pkg::SEC_RED: begin
				r_d = val_s4; g_d = t_s4; b_d = p_s4;
			end
			h2a_pkg::SEC_YELLOW: begin
				r_d = q_s4; g_d = val_s4; b_d = p_s4;
			end
			h2a_pkg::SEC_GREEN: begin
				r_d = p_s4; g_d = val_s4; b_d = t_s4;
			end
			h2a_pkg::SEC_CYAN: begin
				r_d = p_s4; g_d = q_s4; b_d = val_s4;
			end
			h2a_pkg::SEC_BLUE: begin
				r_d = t_s4; g_d = p_s4; b_d = val_s4;
			end
			default: begin
				r_d = val_s4; g_d = p_s4; b_d = q_s4;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (rdy5) begin
			alpha_out <= oor_s4 ? '0 : a_s4;
			red <= oor_s4 ? '0 : r_d;
			green <= oor_s4 ? '0 : g_d;
			blue <= oor_s4 ? '0 : b_d;
			hue_out_of_range <= oor_s4;
		end
	end

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hue_out_of_range |->
			alpha_out == '0 && red == '0 && green == '0 && blue == '0)
		else $error("out-of-range hue beat with nonzero channels");

	a_in_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> v_s1)
		else $error("accepted beat missing from stage 1");

	a_sector_legal: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !oor_s4 |-> sector_s4 <= h2a_pkg::SEC_MAGENTA)
		else $error("in-range beat with sector above five");

	a_s4_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 && !rdy4 |=> v_s4 && $stable(sector_s4) && $stable(p_s4))
		else $error("stage 4 changed while held");

endmodule
